/* design/qba_pkg.sv */
// Package for the quadtree buddy allocator: sizes, node-state and opcode codes,
// level/Z-order helper functions and the controller/datapath interface types.
// No dependencies.
package qba_pkg;

    localparam int LEVELS = 7;
    localparam int NODES  = ((1 << (2 * LEVELS)) - 1) / 3;
    localparam int AW     = $clog2(NODES);
    localparam int IW     = 2 * (LEVELS - 1);
    localparam int LW     = $clog2(LEVELS);
    localparam int PW     = 6;
    localparam int TW     = 33;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NOSPACE  = 2'd1;
    localparam logic [1:0] STS_BADSIZE  = 2'd2;
    localparam logic [1:0] STS_NOTALLOC = 2'd3;

    typedef enum logic [1:0] {
        ST_UNUSED = 2'd0,
        ST_FREE   = 2'd1,
        ST_SPLIT  = 2'd2,
        ST_ALLOC  = 2'd3
    } node_st_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_A_SRCH, S_A_GOT, S_A_LOOP, S_REM, S_S_DESC,
        S_S_ADD, S_F_RD, S_F_TEST, S_M_TOP, S_M_RD, S_M_CHK, S_M_CLR, S_M_NEXT,
        S_M_UP, S_M_UPW, S_L_RD, S_DONE
    } fsm_t;

    typedef enum logic [1:0] {RET_SPLIT, RET_ALLOC, RET_MERGE} ret_t;
    typedef enum logic [1:0] {LV_HOLD, LV_TGT, LV_DEC, LV_INC} lv_op_t;
    typedef enum logic [2:0] {IX_HOLD, IX_MEMRD, IX_ENC, IX_ALIGN, IX_SHL, IX_SHR} idx_op_t;
    typedef enum logic [1:0] {C_HOLD, C_ZERO, C_INC} c_op_t;
    typedef enum logic [1:0] {SET_NONE, SET_ADD, SET_REM} set_op_t;
    typedef enum logic [2:0] {
        RK_ZERO, RK_NOSPACE, RK_BADSIZE, RK_NOTALLOC, RK_ALLOC, RK_LOOKUP
    } res_kind_t;

    typedef struct packed {
        logic      clr;
        logic      load;
        lv_op_t    lv_op;
        idx_op_t   idx_op;
        c_op_t     c_op;
        logic      st_we;
        node_st_t  st_val;
        logic      tag_we;
        logic      tag_set;
        set_op_t   set_op;
        logic      res_load;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] op;
        logic       bad_size;
        logic       cnt_nz;
        logic       lv_zero;
        logic       lv_lt_tgt;
        logic       c_last;
        node_st_t   node_st;
        logic       out_free;
    } sts_t;

    function automatic logic [AW-1:0] lvl_base(input logic [LW-1:0] l);
        logic [AW-1:0] b;
        b = '0;
        for (int k = 0; k < LEVELS; k++) begin
            if (k < int'(l)) begin
                b = b + AW'(1 << (2 * k));
            end
        end
        return b;
    endfunction

    function automatic logic [IW-1:0] zenc(input logic [PW-1:0] x, input logic [PW-1:0] y,
                                           input logic [LW-1:0] l);
        logic [IW-1:0] r;
        r = '0;
        for (int b = 0; b < LEVELS - 1; b++) begin
            if (b < int'(l)) begin
                r[2*b]   = x[b];
                r[2*b+1] = y[b];
            end
        end
        return r;
    endfunction

    function automatic logic [2*PW-1:0] zdec(input logic [IW-1:0] i);
        logic [PW-1:0] x;
        logic [PW-1:0] y;
        x = '0;
        y = '0;
        for (int b = 0; b < LEVELS - 1; b++) begin
            x[b] = i[2*b];
            y[b] = i[2*b+1];
        end
        return {x, y};
    endfunction

endpackage

/* design/qba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* design/qba_ctrl.sv */
// Controller state machine of the quadtree buddy allocator.
// Depends on qba_pkg; drives the datapath through qba_pkg::cmd_t.
module qba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  qba_pkg::sts_t sts,
    output qba_pkg::cmd_t cmd
);
    import qba_pkg::*;

    fsm_t      state_reg, state_next;
    ret_t      ret_reg, ret_next;
    res_kind_t kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ret_reg   <= RET_SPLIT;
            kind_reg  <= RK_ZERO;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        kind_next    = kind_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.lv_op    = LV_HOLD;
        cmd.idx_op   = IX_HOLD;
        cmd.c_op     = C_HOLD;
        cmd.st_val   = ST_UNUSED;
        cmd.set_op   = SET_NONE;
        cmd.res_kind = kind_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.c_op = C_ZERO;
                if (sts.op == OP_NONE) begin
                    kind_next  = RK_ZERO;
                    state_next = S_DONE;
                end else if (sts.bad_size) begin
                    kind_next  = RK_BADSIZE;
                    state_next = S_DONE;
                end else begin
                    cmd.lv_op = LV_TGT;
                    case (sts.op)
                        OP_ALLOC: state_next = S_A_SRCH;
                        OP_FREE: begin
                            cmd.idx_op = IX_ENC;
                            state_next = S_F_RD;
                        end
                        default: begin
                            cmd.idx_op = IX_ENC;
                            state_next = S_L_RD;
                        end
                    endcase
                end
            end
            S_A_SRCH: begin
                if (sts.cnt_nz) begin
                    state_next = S_A_GOT;
                end else if (sts.lv_zero) begin
                    kind_next  = RK_NOSPACE;
                    state_next = S_DONE;
                end else begin
                    cmd.lv_op = LV_DEC;
                end
            end
            S_A_GOT: begin
                cmd.idx_op = IX_MEMRD;
                state_next = S_A_LOOP;
            end
            S_A_LOOP: begin
                cmd.st_we  = 1'b1;
                state_next = S_REM;
                if (sts.lv_lt_tgt) begin
                    cmd.st_val = ST_SPLIT;
                    ret_next   = RET_SPLIT;
                end else begin
                    cmd.st_val  = ST_ALLOC;
                    cmd.tag_we  = 1'b1;
                    cmd.tag_set = 1'b1;
                    ret_next    = RET_ALLOC;
                end
            end
            S_REM: begin
                cmd.set_op = SET_REM;
                case (ret_reg)
                    RET_SPLIT: state_next = S_S_DESC;
                    RET_ALLOC: begin
                        kind_next  = RK_ALLOC;
                        state_next = S_DONE;
                    end
                    default: state_next = S_M_NEXT;
                endcase
            end
            S_S_DESC: begin
                cmd.lv_op  = LV_INC;
                cmd.idx_op = IX_SHL;
                cmd.c_op   = C_ZERO;
                state_next = S_S_ADD;
            end
            S_S_ADD: begin
                cmd.st_we  = 1'b1;
                cmd.st_val = ST_FREE;
                cmd.set_op = SET_ADD;
                if (sts.c_last) begin
                    cmd.c_op   = C_ZERO;
                    state_next = S_A_LOOP;
                end else begin
                    cmd.c_op = C_INC;
                end
            end
            S_F_RD: state_next = S_F_TEST;
            S_F_TEST: begin
                if (sts.node_st != ST_ALLOC) begin
                    kind_next  = RK_NOTALLOC;
                    state_next = S_DONE;
                end else begin
                    cmd.st_we  = 1'b1;
                    cmd.st_val = ST_FREE;
                    cmd.tag_we = 1'b1;
                    cmd.set_op = SET_ADD;
                    state_next = S_M_TOP;
                end
            end
            S_M_TOP: begin
                if (sts.lv_zero) begin
                    kind_next  = RK_ZERO;
                    state_next = S_DONE;
                end else begin
                    cmd.idx_op = IX_ALIGN;
                    cmd.c_op   = C_ZERO;
                    state_next = S_M_RD;
                end
            end
            S_M_RD: state_next = S_M_CHK;
            S_M_CHK: begin
                if (sts.node_st != ST_FREE) begin
                    kind_next  = RK_ZERO;
                    state_next = S_DONE;
                end else if (sts.c_last) begin
                    cmd.c_op   = C_ZERO;
                    state_next = S_M_CLR;
                end else begin
                    cmd.c_op   = C_INC;
                    state_next = S_M_RD;
                end
            end
            S_M_CLR: begin
                cmd.st_we  = 1'b1;
                cmd.st_val = ST_UNUSED;
                ret_next   = RET_MERGE;
                state_next = S_REM;
            end
            S_M_NEXT: begin
                if (sts.c_last) begin
                    state_next = S_M_UP;
                end else begin
                    cmd.c_op   = C_INC;
                    state_next = S_M_CLR;
                end
            end
            S_M_UP: begin
                cmd.lv_op  = LV_DEC;
                cmd.idx_op = IX_SHR;
                cmd.c_op   = C_ZERO;
                state_next = S_M_UPW;
            end
            S_M_UPW: begin
                cmd.st_we  = 1'b1;
                cmd.st_val = ST_FREE;
                cmd.set_op = SET_ADD;
                state_next = S_M_TOP;
            end
            S_L_RD: begin
                kind_next  = RK_LOOKUP;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* design/qba_dp.sv */
// Datapath of the quadtree buddy allocator: request registers, node cursor,
// per-level free-set counts, node-state/free-set/tag RAMs and result register.
// Depends on qba_pkg and qba_ram.
module qba_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  qba_pkg::cmd_t               cmd,
    output qba_pkg::sts_t               sts,
    input  logic [1:0]                  s_opcode,
    input  logic [2:0]                  s_size_log2,
    input  logic [5:0]                  s_pos_x,
    input  logic [5:0]                  s_pos_y,
    input  logic signed [15:0]          s_sector_x,
    input  logic signed [15:0]          s_sector_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [5:0]                  m_out_x,
    output logic [5:0]                  m_out_y,
    output logic signed [15:0]          m_tag_x,
    output logic signed [15:0]          m_tag_y,
    output logic                        m_tag_valid
);
    import qba_pkg::*;

    logic [1:0]         op_reg;
    logic [2:0]         sz_reg;
    logic [PW-1:0]      px_reg, py_reg;
    logic [15:0]        sx_reg, sy_reg;
    logic [LW-1:0]      lv_reg, lv_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [1:0]         c_reg, c_next;
    logic [AW-1:0]      clr_reg;
    logic [AW-1:0]      cnt_reg [LEVELS];
    logic               valid_reg;
    logic [1:0]         status_reg;
    logic [PW-1:0]      ox_reg, oy_reg;
    logic [15:0]        tx_reg, ty_reg;
    logic               tv_reg;

    logic [LW-1:0]      tgt;
    logic [AW-1:0]      base, cnt_cur;
    logic [IW-1:0]      node_idx, enc_idx;
    logic [AW-1:0]      node_addr, mem_raddr;
    logic [1:0]         st_rd;
    logic [IW-1:0]      mem_rd, slot_rd;
    logic [TW-1:0]      tag_rd;
    logic               st_we, mem_we, slot_we, tag_we;
    logic [AW-1:0]      st_waddr, mem_waddr, slot_waddr, tag_waddr;
    logic [1:0]         st_wdata;
    logic [IW-1:0]      mem_wdata, slot_wdata;
    logic [TW-1:0]      tag_wdata;
    logic [2*PW-1:0]    pos;

    assign tgt       = LW'(LEVELS - 1) - LW'(sz_reg);
    assign base      = lvl_base(lv_reg);
    assign cnt_cur   = cnt_reg[lv_reg];
    assign node_idx  = idx_reg | IW'(c_reg);
    assign node_addr = base + AW'(node_idx);
    assign mem_raddr = (cnt_cur != '0) ? base + cnt_cur - AW'(1) : base;
    assign enc_idx   = (op_reg == OP_LOOKUP) ? zenc(px_reg >> sz_reg, py_reg >> sz_reg, tgt)
                                             : zenc(px_reg, py_reg, tgt);
    assign pos       = zdec(idx_reg);

    always_comb begin
        sts.clr_done  = (clr_reg == AW'(NODES - 1));
        sts.op        = op_reg;
        sts.bad_size  = (int'(sz_reg) > LEVELS - 1);
        sts.cnt_nz    = (cnt_cur != '0);
        sts.lv_zero   = (lv_reg == '0);
        sts.lv_lt_tgt = (lv_reg < tgt);
        sts.c_last    = (c_reg == 2'd3);
        sts.node_st   = node_st_t'(st_rd);
        sts.out_free  = !valid_reg || m_ready;
    end

    always_comb begin
        lv_next = lv_reg;
        case (cmd.lv_op)
            LV_TGT:  lv_next = tgt;
            LV_DEC:  lv_next = lv_reg - LW'(1);
            LV_INC:  lv_next = lv_reg + LW'(1);
            default: lv_next = lv_reg;
        endcase
        idx_next = idx_reg;
        case (cmd.idx_op)
            IX_MEMRD: idx_next = mem_rd;
            IX_ENC:   idx_next = enc_idx;
            IX_ALIGN: idx_next = idx_reg & ~IW'(3);
            IX_SHL:   idx_next = idx_reg << 2;
            IX_SHR:   idx_next = idx_reg >> 2;
            default:  idx_next = idx_reg;
        endcase
        c_next = c_reg;
        case (cmd.c_op)
            C_ZERO:  c_next = 2'd0;
            C_INC:   c_next = c_reg + 2'd1;
            default: c_next = c_reg;
        endcase
    end

    always_comb begin
        st_we      = cmd.clr || cmd.st_we;
        st_waddr   = cmd.clr ? clr_reg : node_addr;
        st_wdata   = cmd.clr ? ((clr_reg == '0) ? ST_FREE : ST_UNUSED) : cmd.st_val;
        tag_we     = cmd.clr || cmd.tag_we;
        tag_waddr  = cmd.clr ? clr_reg : node_addr;
        tag_wdata  = (!cmd.clr && cmd.tag_set) ? {1'b1, sx_reg, sy_reg} : '0;
        mem_we     = cmd.clr || (cmd.set_op != SET_NONE);
        mem_waddr  = clr_reg;
        mem_wdata  = '0;
        slot_we    = (cmd.set_op != SET_NONE);
        slot_waddr = base + AW'(node_idx);
        slot_wdata = IW'(cnt_cur);
        case (cmd.set_op)
            SET_ADD: begin
                mem_waddr  = base + cnt_cur;
                mem_wdata  = node_idx;
                slot_waddr = base + AW'(node_idx);
                slot_wdata = IW'(cnt_cur);
            end
            SET_REM: begin
                mem_waddr  = base + AW'(slot_rd);
                mem_wdata  = mem_rd;
                slot_waddr = base + AW'(mem_rd);
                slot_wdata = slot_rd;
            end
            default: begin
                mem_waddr = clr_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_opcode;
            sz_reg <= s_size_log2;
            px_reg <= s_pos_x;
            py_reg <= s_pos_y;
            sx_reg <= s_sector_x;
            sy_reg <= s_sector_y;
        end
        if (cmd.res_load) begin
            status_reg <= STS_OK;
            ox_reg     <= '0;
            oy_reg     <= '0;
            tx_reg     <= '0;
            ty_reg     <= '0;
            tv_reg     <= 1'b0;
            case (cmd.res_kind)
                RK_NOSPACE:  status_reg <= STS_NOSPACE;
                RK_BADSIZE:  status_reg <= STS_BADSIZE;
                RK_NOTALLOC: status_reg <= STS_NOTALLOC;
                RK_ALLOC: begin
                    ox_reg <= pos[2*PW-1:PW];
                    oy_reg <= pos[PW-1:0];
                end
                RK_LOOKUP: begin
                    if (tag_rd[TW-1]) begin
                        tx_reg <= tag_rd[31:16];
                        ty_reg <= tag_rd[15:0];
                        tv_reg <= 1'b1;
                    end
                end
                default: status_reg <= STS_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg    <= '0;
            idx_reg   <= '0;
            c_reg     <= '0;
            clr_reg   <= '0;
            valid_reg <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                cnt_reg[l] <= (l == 0) ? AW'(1) : '0;
            end
        end else begin
            lv_reg  <= lv_next;
            idx_reg <= idx_next;
            c_reg   <= c_next;
            if (cmd.clr && !sts.clr_done) begin
                clr_reg <= clr_reg + AW'(1);
            end
            case (cmd.set_op)
                SET_ADD: cnt_reg[lv_reg] <= cnt_cur + AW'(1);
                SET_REM: cnt_reg[lv_reg] <= cnt_cur - AW'(1);
                default: ;
            endcase
            if (cmd.res_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    qba_ram #(.WIDTH(2), .DEPTH(NODES)) u_state_ram (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(node_addr), .rdata(st_rd)
    );

    qba_ram #(.WIDTH(IW), .DEPTH(NODES)) u_member_ram (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rd)
    );

    qba_ram #(.WIDTH(IW), .DEPTH(NODES)) u_slot_ram (
        .aclk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(node_addr), .rdata(slot_rd)
    );

    qba_ram #(.WIDTH(TW), .DEPTH(NODES)) u_tag_ram (
        .aclk(aclk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
        .raddr(node_addr), .rdata(tag_rd)
    );

    assign m_valid     = valid_reg;
    assign m_status    = status_reg;
    assign m_out_x     = ox_reg;
    assign m_out_y     = oy_reg;
    assign m_tag_x     = tx_reg;
    assign m_tag_y     = ty_reg;
    assign m_tag_valid = tv_reg;

endmodule

/* design/quadtree_buddy_allocator_unit.sv */
// Quadtree buddy allocator top level: controller plus datapath.
// Depends on qba_pkg, qba_ctrl, qba_dp (and qba_ram through qba_dp).
//
// Two-dimensional buddy allocator over a 7-level quadtree (5461 nodes), one
// request at a time. After reset the node-state, free-set member and tag RAMs
// are swept, one node per cycle, before s_ready first rises. A lookup decodes
// the request, reads the node tag and loads the result. An alloc searches
// upward for a level with a free node, takes its last member and splits down
// to the target level; an alloc that finds no space ends when the search
// reaches the root level. A free checks that the node is allocated, returns
// it to its free set and merges upward while all four siblings are free.
// Each free-set removal uses the registered RAM reads of the slot and last
// member and rewrites both; every split adds its four children one per cycle,
// and every merge checks and then clears its four children one at a time.
// A result is loaded only once the previous one has been accepted. The
// result sits in an output register, so the next request is taken while it
// waits for m_ready.
module quadtree_buddy_allocator_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [2:0]         s_size_log2,
    input  logic [5:0]         s_pos_x,
    input  logic [5:0]         s_pos_y,
    input  logic signed [15:0] s_sector_x,
    input  logic signed [15:0] s_sector_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [5:0]         m_out_x,
    output logic [5:0]         m_out_y,
    output logic signed [15:0] m_tag_x,
    output logic signed [15:0] m_tag_y,
    output logic               m_tag_valid
);
    import qba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    qba_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    qba_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_opcode(s_opcode), .s_size_log2(s_size_log2), .s_pos_x(s_pos_x),
        .s_pos_y(s_pos_y), .s_sector_x(s_sector_x), .s_sector_y(s_sector_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_tag_x(m_tag_x),
        .m_tag_y(m_tag_y), .m_tag_valid(m_tag_valid)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transaction accepted while a request is in flight");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> (!m_valid || m_ready))
        else $error("result register overwritten before its transaction completed");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr |-> !s_ready && !cmd.st_we && cmd.set_op == SET_NONE)
        else $error("request activity during the clearing sweep");

endmodule
